[rtl/nrle_pkg.sv]
`timescale 1ns / 1ps

package nrle_pkg;

	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_DATA   = 1'b1;

	localparam logic [1:0] KIND_TILE    = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_CORRUPT = 2'd2;

	localparam logic [7:0] HEADER_BYTES = 8'd4;
	localparam logic [3:0] REP_BIAS     = 4'd6;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CODE,
		PH_LIT,
		PH_REP
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NIB,
		ST_CHECK,
		ST_FLUSH
	} ctl_state_t;

	typedef struct packed {
		logic ready;
		logic load;
		logic nib;
		logic chk;
		logic flush;
	} ctl_cmd_t;

	typedef struct packed {
		phase_t phase;
		logic   load_end;
		logic   nib_emit;
		logic   nib_end;
		logic   nib_check;
		logic   chk_emit;
		logic   chk_end;
		logic   pend_valid;
		logic   out_free;
	} dp_status_t;

endpackage

[rtl/nrle_item_if.sv]
`timescale 1ns / 1ps

interface nrle_item_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] row;
	logic [7:0] start_col;
	logic [7:0] end_col;
	logic [7:0] run_bytes;
	logic [7:0] data_byte;

	modport source (
		output valid, opcode, row, start_col, end_col, run_bytes, data_byte,
		input  ready
	);

	modport sink (
		input  valid, opcode, row, start_col, end_col, run_bytes, data_byte,
		output ready
	);
endinterface

[rtl/nrle_result_if.sv]
`timescale 1ns / 1ps

interface nrle_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_row;
	logic [7:0] out_col;
	logic [3:0] tile;
	logic       last;

	modport source (
		output valid, kind, out_row, out_col, tile, last,
		input  ready
	);

	modport sink (
		input  valid, kind, out_row, out_col, tile, last,
		output ready
	);
endinterface

[rtl/nrle_datapath.sv]
`timescale 1ns / 1ps

module nrle_datapath #(
	parameter int unsigned MAP_WIDTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nrle_pkg::ctl_cmd_t   cmd,
	input  logic                 opcode,
	input  logic [7:0]           row,
	input  logic [7:0]           start_col,
	input  logic [7:0]           end_col,
	input  logic [7:0]           run_bytes,
	input  logic [7:0]           data_byte,
	input  logic                 res_ready,
	output nrle_pkg::dp_status_t st,
	output logic                 res_valid,
	output logic [1:0]           kind,
	output logic [7:0]           out_row,
	output logic [7:0]           out_col,
	output logic [3:0]           tile,
	output logic                 last
);

	localparam logic [8:0] COL_LIMIT = 9'(MAP_WIDTH);

	nrle_pkg::phase_t phase_q;
	logic [7:0] row_q;
	logic [8:0] col_q;
	logic [7:0] stop_q;
	logic [7:0] bytes_q;
	logic [3:0] lit_q;
	logic [3:0] rep_q;
	logic [7:0] byte_q;
	logic       half_q;

	logic       pend_valid_q;
	logic [1:0] pend_kind_q;
	logic [7:0] pend_col_q;
	logic [3:0] pend_tile_q;

	logic       out_valid_q;
	logic [1:0] out_kind_q;
	logic [7:0] out_row_q;
	logic [7:0] out_col_q;
	logic [3:0] out_tile_q;
	logic       out_last_q;

	logic [3:0] nib;
	logic [8:0] avail;
	logic       code_lit;
	logic       lit_short;
	logic       rep_short;
	logic       overflow;
	logic       at_end;
	logic       out_free;

	logic       hdr_empty;
	logic       hdr_emit;
	logic [1:0] hdr_kind;
	logic       dat_idle;
	logic       dat_emit;
	logic       load_emit;
	logic       load_end;

	logic       nib_emit;
	logic       nib_end;
	logic       nib_check;
	logic [1:0] nib_kind;
	logic       chk_emit;
	logic       chk_end;
	logic [1:0] chk_kind;

	logic       emit;
	logic       move;
	logic [1:0] new_kind;
	logic [7:0] new_col;
	logic [3:0] new_tile;

	assign nib       = half_q ? byte_q[3:0] : byte_q[7:4];
	assign avail     = {bytes_q, 1'b0} + {8'd0, ~half_q};
	assign code_lit  = ~nib[3];
	assign lit_short = ({5'd0, nib} + 9'd1) > avail;
	assign rep_short = (avail == 9'd0);
	assign overflow  = (col_q >= COL_LIMIT);
	assign at_end    = (col_q >= {1'b0, stop_q});
	assign out_free  = ~out_valid_q | res_ready;

	assign hdr_empty = (start_col >= end_col);
	assign hdr_emit  = hdr_empty | (run_bytes <= nrle_pkg::HEADER_BYTES);
	assign hdr_kind  = (hdr_empty && run_bytes == nrle_pkg::HEADER_BYTES) ?
		nrle_pkg::KIND_DONE : nrle_pkg::KIND_CORRUPT;
	assign dat_idle  = (phase_q == nrle_pkg::PH_IDLE);
	assign dat_emit  = ~dat_idle & (bytes_q == 8'd0);
	assign load_emit = (opcode == nrle_pkg::OP_HEADER) ? hdr_emit : dat_emit;
	assign load_end  = (opcode == nrle_pkg::OP_HEADER) | dat_idle | (bytes_q == 8'd0);

	always_comb begin
		nib_emit  = 1'b0;
		nib_end   = 1'b1;
		nib_check = 1'b0;
		nib_kind  = nrle_pkg::KIND_CORRUPT;
		unique case (phase_q)
			nrle_pkg::PH_CODE: begin
				nib_emit = code_lit ? lit_short : rep_short;
				nib_end  = nib_emit | half_q;
			end
			nrle_pkg::PH_LIT: begin
				nib_emit = 1'b1;
				if (!overflow) begin
					nib_kind = nrle_pkg::KIND_TILE;
					if (lit_q == 4'd1) begin
						nib_check = 1'b1;
						nib_end   = 1'b0;
					end else begin
						nib_end = half_q;
					end
				end
			end
			nrle_pkg::PH_REP: begin
				nib_emit = 1'b1;
				if (!overflow) begin
					nib_kind  = nrle_pkg::KIND_TILE;
					nib_end   = 1'b0;
					nib_check = (rep_q == 4'd1);
				end
			end
			default: begin
				nib_emit = 1'b0;
			end
		endcase
	end

	assign chk_emit = at_end | (avail == 9'd0);
	assign chk_end  = chk_emit | half_q;
	assign chk_kind = (at_end && bytes_q == 8'd0) ?
		nrle_pkg::KIND_DONE : nrle_pkg::KIND_CORRUPT;

	assign emit = (cmd.load & load_emit) | (cmd.nib & nib_emit) | (cmd.chk & chk_emit);
	assign move = (emit | cmd.flush) & pend_valid_q;

	always_comb begin
		new_col  = 8'd0;
		new_tile = 4'd0;
		if (cmd.load) begin
			new_kind = (opcode == nrle_pkg::OP_HEADER) ? hdr_kind : nrle_pkg::KIND_CORRUPT;
		end else if (cmd.nib) begin
			new_kind = nib_kind;
			if (nib_kind == nrle_pkg::KIND_TILE) begin
				new_col  = col_q[7:0];
				new_tile = nib;
			end
		end else begin
			new_kind = chk_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nrle_pkg::PH_IDLE;
			row_q   <= 8'd0;
			col_q   <= 9'd0;
			stop_q  <= 8'd0;
			bytes_q <= 8'd0;
			lit_q   <= 4'd0;
			rep_q   <= 4'd0;
			half_q  <= 1'b0;
		end else if (cmd.load) begin
			if (opcode == nrle_pkg::OP_HEADER) begin
				row_q   <= row;
				col_q   <= {1'b0, start_col};
				stop_q  <= end_col;
				lit_q   <= 4'd0;
				rep_q   <= 4'd0;
				bytes_q <= hdr_emit ? 8'd0 : run_bytes - nrle_pkg::HEADER_BYTES;
				phase_q <= hdr_emit ? nrle_pkg::PH_IDLE : nrle_pkg::PH_CODE;
			end else begin
				half_q <= 1'b0;
				if (!dat_idle) begin
					if (bytes_q == 8'd0) begin
						phase_q <= nrle_pkg::PH_IDLE;
					end else begin
						bytes_q <= bytes_q - 8'd1;
					end
				end
			end
		end else if (cmd.nib) begin
			unique case (phase_q)
				nrle_pkg::PH_CODE: begin
					if (nib_emit) begin
						phase_q <= nrle_pkg::PH_IDLE;
					end else if (code_lit) begin
						lit_q   <= nib + 4'd1;
						phase_q <= nrle_pkg::PH_LIT;
						half_q  <= 1'b1;
					end else begin
						rep_q   <= nib - nrle_pkg::REP_BIAS;
						phase_q <= nrle_pkg::PH_REP;
						half_q  <= 1'b1;
					end
				end
				nrle_pkg::PH_LIT: begin
					if (overflow) begin
						phase_q <= nrle_pkg::PH_IDLE;
					end else begin
						col_q <= col_q + 9'd1;
						lit_q <= lit_q - 4'd1;
						if (lit_q == 4'd1) begin
							phase_q <= nrle_pkg::PH_CODE;
						end else begin
							half_q <= 1'b1;
						end
					end
				end
				nrle_pkg::PH_REP: begin
					if (overflow) begin
						phase_q <= nrle_pkg::PH_IDLE;
					end else begin
						col_q <= col_q + 9'd1;
						rep_q <= rep_q - 4'd1;
						if (rep_q == 4'd1) begin
							phase_q <= nrle_pkg::PH_CODE;
						end
					end
				end
				default: begin
					phase_q <= nrle_pkg::PH_IDLE;
				end
			endcase
		end else if (cmd.chk) begin
			if (chk_emit) begin
				phase_q <= nrle_pkg::PH_IDLE;
			end else begin
				half_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && opcode == nrle_pkg::OP_DATA) begin
			byte_q <= data_byte;
		end
		if (emit) begin
			pend_kind_q <= new_kind;
			pend_col_q  <= new_col;
			pend_tile_q <= new_tile;
		end
		if (move) begin
			out_kind_q <= pend_kind_q;
			out_row_q  <= row_q;
			out_col_q  <= pend_col_q;
			out_tile_q <= pend_tile_q;
			out_last_q <= cmd.flush;
		end
	end

	assign st.phase      = phase_q;
	assign st.load_end   = load_end;
	assign st.nib_emit   = nib_emit;
	assign st.nib_end    = nib_end;
	assign st.nib_check  = nib_check;
	assign st.chk_emit   = chk_emit;
	assign st.chk_end    = chk_end;
	assign st.pend_valid = pend_valid_q;
	assign st.out_free   = out_free;

	assign res_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign tile      = out_tile_q;
	assign last      = out_last_q;

endmodule

[rtl/nrle_controller.sv]
`timescale 1ns / 1ps

module nrle_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  nrle_pkg::dp_status_t st,
	output nrle_pkg::ctl_cmd_t   cmd
);

	nrle_pkg::ctl_state_t state_q;
	nrle_pkg::ctl_state_t state_d;
	logic                 pend_ok;

	assign pend_ok = ~st.pend_valid | st.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nrle_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			nrle_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = st.load_end ? nrle_pkg::ST_FLUSH : nrle_pkg::ST_NIB;
				end
			end
			nrle_pkg::ST_NIB: begin
				if (!st.nib_emit || pend_ok) begin
					cmd.nib = 1'b1;
					if (st.nib_end) begin
						state_d = nrle_pkg::ST_FLUSH;
					end else if (st.nib_check) begin
						state_d = nrle_pkg::ST_CHECK;
					end
				end
			end
			nrle_pkg::ST_CHECK: begin
				if (!st.chk_emit || pend_ok) begin
					cmd.chk = 1'b1;
					state_d = st.chk_end ? nrle_pkg::ST_FLUSH : nrle_pkg::ST_NIB;
				end
			end
			nrle_pkg::ST_FLUSH: begin
				if (pend_ok) begin
					cmd.flush = 1'b1;
					state_d   = nrle_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nrle_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/nibble_rle_row_decoder.sv]
`timescale 1ns / 1ps

// Decodes one row segment of a nibble run-length tile map.
// The item channel takes a header transfer (row, start and end column, run length in
// bytes including the 4-byte header) and then payload byte transfers, high nibble first.
// The result channel gives one transfer per tile write, and a final status transfer
// (clean completion or corruption) when the run ends; last marks the final result
// caused by each item.
// One item is handled at a time. A header is loaded and then its result is released;
// its status result passes through the holding register and then the output register
// before it is offered. A data byte is loaded, then steps through its tile writes, its
// code nibbles and its end checks after a group, and a final step releases its final
// result. The rate is set by the single tile-write path of the datapath, which emits
// one result per cycle unless the receiver stalls with both result registers full.
// Results pass through a holding register and an output register, so a new item is
// accepted while the previous item's final result still waits at the output.
// When the receiver stalls, decoding pauses as soon as both registers are full.
// Reset clears the run state to idle and empties both result registers.

module nibble_rle_row_decoder #(
	parameter int unsigned MAP_WIDTH = 256
) (
	input logic          clk,
	input logic          arst_n,
	nrle_item_if.sink    item,
	nrle_result_if.source result
);

	nrle_pkg::ctl_cmd_t   cmd;
	nrle_pkg::dp_status_t st;

	nrle_controller u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.st       (st),
		.cmd      (cmd)
	);

	nrle_datapath #(
		.MAP_WIDTH (MAP_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.opcode    (item.opcode),
		.row       (item.row),
		.start_col (item.start_col),
		.end_col   (item.end_col),
		.run_bytes (item.run_bytes),
		.data_byte (item.data_byte),
		.res_ready (result.ready),
		.st        (st),
		.res_valid (result.valid),
		.kind      (result.kind),
		.out_row   (result.out_row),
		.out_col   (result.out_col),
		.tile      (result.tile),
		.last      (result.last)
	);

	assign item.ready = cmd.ready;

`ifndef SYNTHESIS
	a_idle_holds_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !st.pend_valid)
		else $error("Holding register occupied while waiting for an item.");

	a_step_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.nib |-> st.phase != nrle_pkg::PH_IDLE)
		else $error("Nibble step issued with no open run.");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.kind != nrle_pkg::KIND_TILE) |-> result.last)
		else $error("Status result not marked as the final result of its item.");
`endif

endmodule
